>>> hw/rtl/sem_pkg.sv
package sem_pkg;

  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);       // column counter
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT) + 1;  // row counter, holds the height
  localparam int unsigned WREG_W = 12;
  localparam int unsigned HREG_W = 13;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WREG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [HREG_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [WREG_W-1:0] WIDTH_MAX    = WREG_W'(MAX_WIDTH);
  localparam logic [HREG_W-1:0] HEIGHT_MAX   = HREG_W'(MAX_HEIGHT);

  typedef logic [31:0] pix_t;            // bgra, blue in the low byte
  typedef pix_t [8:0] win_t;             // 3x3 window, row major
  typedef logic [2:0][7:0] mag_t;        // blue, green, red

  typedef struct packed {
    logic busy;
    logic done;
  } mag_stat_t;

endpackage

>>> hw/rtl/sem_if.sv
interface sem_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_in;
  logic [7:0] green_in;
  logic [7:0] red_in;
  logic [7:0] alpha_in;
  logic       frame_start;

  modport source (output valid, blue_in, green_in, red_in, alpha_in, frame_start,
                  input ready);
  modport sink   (input valid, blue_in, green_in, red_in, alpha_in, frame_start,
                  output ready);
endinterface

interface sem_res_if;
  logic        valid;
  logic        ready;
  logic [10:0] out_col;
  logic [11:0] out_row;
  logic [7:0]  blue_out;
  logic [7:0]  green_out;
  logic [7:0]  red_out;
  logic [7:0]  alpha_out;

  modport source (output valid, out_col, out_row, blue_out, green_out, red_out, alpha_out,
                  input ready);
  modport sink   (input valid, out_col, out_row, blue_out, green_out, red_out, alpha_out,
                  output ready);
endinterface

>>> hw/rtl/sobel_edge_magnitude_rgb_unit.sv
// sobel gradient magnitude over a bgra pixel stream
// pixels enter on pix_i in raster order, one beat per pixel; frame_start on
// a beat restarts the column and row count at that pixel. image_width and
// image_height must be written through the cfg port only while the unit is
// idle; the unit does not check it. for each interior pixel one beat leaves
// on res_o carrying its column and row, the clamped magnitude for blue,
// green and red and the centre alpha; border pixels and pixels past the
// last row give no beat. one pixel is worked at a time: accept (line store
// read issued), the calc step shifts the window and writes both line
// stores, then the square root unit works out the roots of all three
// channels bit by bit. a border pixel returns to idle after the calc step
// and a pixel past the last row is dropped at accept; for a pixel with a
// result pix_i is ready again on the cycle after the result is loaded into
// the output register, which keeps the result while the receiver stalls
// and lets the next pixel in; a second result waits in the root unit until
// the output register is free.
// reset clears counters, window and handshakes and loads width 640 and
// height 480; line stores hold nothing until a frame has been streamed.
module sobel_edge_magnitude_rgb_unit import sem_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sem_pix_if.sink               pix_i,
  sem_res_if.source             res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_MAG  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [WREG_W-1:0] width_q;
  logic [HREG_W-1:0] height_q;
  logic [WREG_W-1:0] w_eff;
  logic [HREG_W-1:0] h_eff;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  // position and pixel of the beat in work
  logic [COL_W-1:0] c_q;
  logic [ROW_W-1:0] r_q;
  pix_t             px_q;
  logic             emit_q;

  win_t win_q;
  pix_t upper_rd, lower_rd;

  mag_stat_t mag_st;
  mag_t      mag;

  logic [COL_W-1:0] c0, c1;
  logic [ROW_W-1:0] r0, r1;
  logic [WREG_W-1:0] c_next;
  logic             accept, ignore, load_out;

  logic             out_valid_q;
  logic [10:0]      out_col_q;
  logic [11:0]      out_row_q;
  mag_t             out_mag_q;
  logic [7:0]       out_alpha_q;

  // register values out of range act as the nearest legal value
  assign w_eff = (width_q == '0) ? WREG_W'(1) : ((width_q > WIDTH_MAX) ? WIDTH_MAX : width_q);
  assign h_eff = (height_q == '0) ? HREG_W'(1) : ((height_q > HEIGHT_MAX) ? HEIGHT_MAX : height_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WREG_W-1:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[HREG_W-1:0];
        default: ;
      endcase
    end
  end

  assign pix_i.ready = (state_q == ST_IDLE);
  assign accept      = pix_i.valid && pix_i.ready;

  // position of the incoming beat: frame start, then wrap of a stale column
  always_comb begin
    c0 = pix_i.frame_start ? '0 : col_q;
    r0 = pix_i.frame_start ? '0 : row_q;
    c1 = c0;
    r1 = r0;
    if ({1'b0, c0} >= w_eff) begin
      c1 = '0;
      if (r0 < h_eff) begin
        r1 = r0 + ROW_W'(1);
      end
    end
    ignore = (r1 >= h_eff);
    c_next = {1'b0, c1} + WREG_W'(1);
    col_d  = col_q;
    row_d  = row_q;
    if (accept) begin
      if (ignore) begin
        col_d = c1;
        row_d = r1;
      end else if (c_next >= w_eff) begin
        col_d = '0;
        row_d = r1 + ROW_W'(1);
      end else begin
        col_d = c_next[COL_W-1:0];
        row_d = r1;
      end
    end
  end

  // line stores: read at accept, written back in the calc cycle
  sem_line_ram #(.DEPTH(MAX_WIDTH), .WIDTH(32)) u_upper (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_CALC),
    .waddr_i (c_q),
    .wdata_i (lower_rd),
    .raddr_i (c1),
    .rdata_o (upper_rd)
  );

  sem_line_ram #(.DEPTH(MAX_WIDTH), .WIDTH(32)) u_lower (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_CALC),
    .waddr_i (c_q),
    .wdata_i (px_q),
    .raddr_i (c1),
    .rdata_o (lower_rd)
  );

  sem_mag u_mag (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_MAG && !mag_st.busy && !mag_st.done && emit_q),
    .win_i   (win_q),
    .stat_o  (mag_st),
    .mag_o   (mag)
  );

  assign load_out = (state_q == ST_OUT) && (!out_valid_q || res_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept && !ignore) state_d = ST_CALC;
      ST_CALC: state_d = emit_q ? ST_MAG : ST_IDLE;
      ST_MAG:  if (mag_st.done) state_d = ST_OUT;
      ST_OUT:  if (load_out) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      win_q       <= '0;
      emit_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      if (accept && !ignore) begin
        emit_q <= (c1 >= COL_W'(2)) && (r1 >= ROW_W'(2));
      end
      // window moves one column left, new column from the stores and the beat
      if (state_q == ST_CALC) begin
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
        win_q[3] <= win_q[4];
        win_q[4] <= win_q[5];
        win_q[6] <= win_q[7];
        win_q[7] <= win_q[8];
        win_q[2] <= upper_rd;
        win_q[5] <= lower_rd;
        win_q[8] <= px_q;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !ignore) begin
      c_q  <= c1;
      r_q  <= r1;
      px_q <= {pix_i.alpha_in, pix_i.red_in, pix_i.green_in, pix_i.blue_in};
    end
    if (load_out) begin
      out_col_q   <= c_q - COL_W'(1);
      out_row_q   <= r_q[11:0] - 12'd1;
      out_mag_q   <= mag;
      out_alpha_q <= win_q[4][31:24];
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.out_col   = out_col_q;
  assign res_o.out_row   = out_row_q;
  assign res_o.blue_out  = out_mag_q[0];
  assign res_o.green_out = out_mag_q[1];
  assign res_o.red_out   = out_mag_q[2];
  assign res_o.alpha_out = out_alpha_q;

  // a border pixel goes straight back to idle after the store update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CALC && !emit_q |=> state_q == ST_IDLE)
    else $error("border pixel did not return to idle");

  // the root unit only finishes while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mag_st.done |-> state_q == ST_MAG)
    else $error("root unit done outside of wait");

  // a new result only comes from the output load step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_OUT)
    else $error("result valid without load");

  // the root unit is idle whenever a pixel can be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.ready |-> !mag_st.busy)
    else $error("pixel taken while root unit busy");

endmodule

>>> hw/rtl/sem_line_ram.sv
module sem_line_ram #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/sem_mag.sv
module sem_mag import sem_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  win_t      win_i,
  output mag_stat_t stat_o,
  output mag_t      mag_o
);

  typedef enum logic [1:0] {
    MS_IDLE = 2'b01,
    MS_ROOT = 2'b10
  } mag_state_e;

  mag_state_e state_q, state_d;
  logic [2:0]       bit_q, bit_d;
  logic             done_q, done_d;
  logic [2:0][20:0] sq_q, sq_d;
  logic [2:0][7:0]  res_q, res_d;

  function automatic logic signed [11:0] chan(pix_t p, int unsigned ch);
    chan = $signed({4'b0, p[ch*8 +: 8]});
  endfunction

  always_comb begin
    logic signed [11:0] gx, gy;
    logic signed [23:0] sx, sy;
    logic [7:0]         t;
    logic [15:0]        tt;
    state_d = state_q;
    bit_d   = bit_q;
    done_d  = 1'b0;
    sq_d    = sq_q;
    res_d   = res_q;
    for (int unsigned ch = 0; ch < 3; ch++) begin
      gx = (chan(win_i[2], ch) - chan(win_i[0], ch))
         + 12'sd2 * (chan(win_i[5], ch) - chan(win_i[3], ch))
         + (chan(win_i[8], ch) - chan(win_i[6], ch));
      gy = (chan(win_i[6], ch) + 12'sd2 * chan(win_i[7], ch) + chan(win_i[8], ch))
         - (chan(win_i[0], ch) + 12'sd2 * chan(win_i[1], ch) + chan(win_i[2], ch));
      sx = gx * gx;
      sy = gy * gy;
      t  = res_q[ch] | (8'd1 << bit_q);
      tt = t * t;
      case (state_q)
        MS_IDLE: begin
          if (start_i) begin
            sq_d[ch]  = sx[20:0] + sy[20:0];
            res_d[ch] = 8'd0;
          end
        end
        MS_ROOT: begin
          if (tt <= sq_q[ch][15:0]) begin
            res_d[ch] = t;
          end
        end
        default: ;
      endcase
    end
    case (state_q)
      MS_IDLE: begin
        if (start_i) begin
          state_d = MS_ROOT;
          bit_d   = 3'd7;
        end
      end
      MS_ROOT: begin
        bit_d = bit_q - 3'd1;
        if (bit_q == 3'd0) begin
          state_d = MS_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = MS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MS_IDLE;
      bit_q   <= 3'd0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q  <= sq_d;
    res_q <= res_d;
  end

  // anything from 2^16 up is past 255
  always_comb begin
    for (int unsigned ch = 0; ch < 3; ch++) begin
      mag_o[ch] = (sq_q[ch][20:16] != 5'd0) ? 8'hff : res_q[ch];
    end
  end

  assign stat_o.busy = (state_q == MS_ROOT);
  assign stat_o.done = done_q;

endmodule
